@@ design/pfc_pkg.sv @@
// Shared types, constants and helpers for the Playfair digraph cipher core.
`timescale 1ns / 1ps
`default_nettype none
package pfc_pkg;

   localparam int SQ_DIM    = 5;
   localparam int CODE_W    = 5;
   localparam int IDX_W     = 3;
   localparam int ROW_W     = SQ_DIM * CODE_W;
   localparam int CELLS     = SQ_DIM * SQ_DIM;
   localparam int CSR_IDX_W = 3;

   typedef logic [CODE_W-1:0] letter_type;
   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [CELLS-1:0] match_type;
   typedef logic [SQ_DIM-1:0][SQ_DIM-1:0][CODE_W-1:0] square_type;
   typedef logic [SQ_DIM-1:0][ROW_W-1:0] rows_type;

   typedef enum logic {
      MODE_ENCRYPT = 1'b0,
      MODE_DECRYPT = 1'b1
   } mode_type;

   typedef struct packed {
      logic    found;
      idx_type row;
      idx_type col;
   } pos_type;

   localparam letter_type CODE_J = letter_type'(9);
   localparam letter_type CODE_I = letter_type'(8);
   localparam idx_type    IDX_LAST = idx_type'(SQ_DIM - 1);
   localparam idx_type    IDX_ZERO = idx_type'(0);

   localparam rows_type SQUARE_RESET = {
      25'd27025109, 25'd21613104, 25'd16201099, 25'd10755269, 25'd4294688
   };

   // one step around the square, forward or backward
   function automatic idx_type wrap_step(input idx_type idx, input mode_type mode);
      idx_type res;
      if (mode == MODE_DECRYPT) begin
         res = (idx == IDX_ZERO) ? IDX_LAST : idx_type'(idx - idx_type'(1));
      end else begin
         res = (idx == IDX_LAST) ? IDX_ZERO : idx_type'(idx + idx_type'(1));
      end
      return res;
   endfunction

endpackage
`default_nettype wire

@@ design/playfair_digraph_cipher_core.sv @@
// Top level: key square registers and four-stage Playfair digraph pipeline.
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/req_stall | mode, first_letter, second_letter
//   rsp     | out       | rsp_valid/rsp_stall | first_result, second_result, not_found
//   csr     | in        | csr_valid/csr_ready | csr_index, csr_data
//
// A request passes the input register, entry compare, priority encode, and
// rule select and lookup into the output register. One request per cycle
// unless req_stall is high. A stage loads whenever it is empty or the stage
// after it moves, so bubbles are squeezed out under rsp_stall. Reset clears
// all valids and loads the default square; csr writes are always taken.
`timescale 1ns / 1ps
`default_nettype none
module playfair_digraph_cipher_core (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_stall,
   input  wire                          req_mode,
   input  wire pfc_pkg::letter_type     req_first_letter,
   input  wire pfc_pkg::letter_type     req_second_letter,
   output logic                         rsp_valid,
   input  wire                          rsp_stall,
   output pfc_pkg::letter_type          rsp_first_result,
   output pfc_pkg::letter_type          rsp_second_result,
   output logic                         rsp_not_found,
   input  wire                          csr_valid,
   output logic                         csr_ready,
   input  wire [pfc_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire [pfc_pkg::ROW_W-1:0]     csr_data
);
   import pfc_pkg::*;

   rows_type   square_ff, square_in;
   square_type square;

   logic       s1_valid_ff, s1_valid_in;
   mode_type   s1_mode_ff;
   letter_type s1_a_ff, s1_b_ff;

   logic       s2_valid_ff, s2_valid_in;
   mode_type   s2_mode_ff;
   match_type  s2_a_ff, s2_b_ff;
   match_type  hits_a, hits_b;

   logic       s3_valid_ff, s3_valid_in;
   mode_type   s3_mode_ff;
   pos_type    s3_a_ff, s3_b_ff;
   pos_type    pos_a, pos_b;

   logic       s4_valid_ff, s4_valid_in;
   letter_type s4_a_ff, s4_b_ff;
   logic       s4_nf_ff;
   letter_type res_a, res_b;
   logic       nf;

   logic       adv1, adv2, adv3, adv4;

   assign square    = square_type'(square_ff);
   assign csr_ready = 1'b1;

   always_comb begin
      square_in = square_ff;
      if (csr_valid && csr_ready && (csr_index < CSR_IDX_W'(SQ_DIM))) begin
         square_in[csr_index] = csr_data;
      end
   end

   assign adv4 = !s4_valid_ff || !rsp_stall;
   assign adv3 = !s3_valid_ff || adv4;
   assign adv2 = !s2_valid_ff || adv3;
   assign adv1 = !s1_valid_ff || adv2;

   assign req_stall   = !adv1;
   assign s1_valid_in = adv1 ? req_valid   : s1_valid_ff;
   assign s2_valid_in = adv2 ? s1_valid_ff : s2_valid_ff;
   assign s3_valid_in = adv3 ? s2_valid_ff : s3_valid_ff;
   assign s4_valid_in = adv4 ? s3_valid_ff : s4_valid_ff;

   pfc_match u_match_a (.letter(s1_a_ff), .square(square), .hits(hits_a));
   pfc_match u_match_b (.letter(s1_b_ff), .square(square), .hits(hits_b));

   pfc_encode u_encode_a (.hits(s2_a_ff), .pos(pos_a));
   pfc_encode u_encode_b (.hits(s2_b_ff), .pos(pos_b));

   pfc_xform u_xform (
      .mode      (s3_mode_ff),
      .pos_a     (s3_a_ff),
      .pos_b     (s3_b_ff),
      .square    (square),
      .res_a     (res_a),
      .res_b     (res_b),
      .not_found (nf)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         square_ff   <= SQUARE_RESET;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         square_ff   <= square_in;
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
         s4_valid_ff <= s4_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         s1_mode_ff <= mode_type'(req_mode);
         s1_a_ff    <= req_first_letter;
         s1_b_ff    <= req_second_letter;
      end
      if (adv2) begin
         s2_mode_ff <= s1_mode_ff;
         s2_a_ff    <= hits_a;
         s2_b_ff    <= hits_b;
      end
      if (adv3) begin
         s3_mode_ff <= s2_mode_ff;
         s3_a_ff    <= pos_a;
         s3_b_ff    <= pos_b;
      end
      if (adv4) begin
         s4_a_ff  <= res_a;
         s4_b_ff  <= res_b;
         s4_nf_ff <= nf;
      end
   end

   assign rsp_valid         = s4_valid_ff;
   assign rsp_first_result  = s4_a_ff;
   assign rsp_second_result = s4_b_ff;
   assign rsp_not_found     = s4_nf_ff;

   a_not_found_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_not_found |-> rsp_first_result == '0 && rsp_second_result == '0)
      else $error("not_found response carries nonzero letters");

   a_req_enters: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> s1_valid_ff)
      else $error("accepted request did not reach stage one");

   a_s3_to_out: assert property (@(posedge clock) disable iff (reset)
      s3_valid_ff && adv4 |=> rsp_valid)
      else $error("stage three item lost on the way to the output");

   a_stall_means_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff && s2_valid_ff && s3_valid_ff && s4_valid_ff)
      else $error("request stalled with a bubble in the pipeline");

endmodule
`default_nettype wire

@@ design/pfc_match.sv @@
// Letter compare against all square entries, J folded onto I.
`timescale 1ns / 1ps
`default_nettype none
module pfc_match (
   input  wire pfc_pkg::letter_type letter,
   input  wire pfc_pkg::square_type square,
   output pfc_pkg::match_type       hits
);
   import pfc_pkg::*;

   letter_type key;

   assign key = (letter == CODE_J) ? CODE_I : letter;

   always_comb begin
      for (int r = 0; r < SQ_DIM; r++) begin
         for (int c = 0; c < SQ_DIM; c++) begin
            hits[r*SQ_DIM + c] = (square[r][c] == key);
         end
      end
   end

endmodule
`default_nettype wire

@@ design/pfc_encode.sv @@
// First-hit priority encoder from match vector to row and column.
`timescale 1ns / 1ps
`default_nettype none
module pfc_encode (
   input  wire pfc_pkg::match_type hits,
   output pfc_pkg::pos_type        pos
);
   import pfc_pkg::*;

   always_comb begin
      pos = '0;
      for (int r = SQ_DIM - 1; r >= 0; r--) begin
         for (int c = SQ_DIM - 1; c >= 0; c--) begin
            if (hits[r*SQ_DIM + c]) begin
               pos.found = 1'b1;
               pos.row   = idx_type'(r);
               pos.col   = idx_type'(c);
            end
         end
      end
   end

endmodule
`default_nettype wire

@@ design/pfc_xform.sv @@
// Digraph rule: same row, same column or rectangle swap, then square lookup.
`timescale 1ns / 1ps
`default_nettype none
module pfc_xform (
   input  wire pfc_pkg::mode_type   mode,
   input  wire pfc_pkg::pos_type    pos_a,
   input  wire pfc_pkg::pos_type    pos_b,
   input  wire pfc_pkg::square_type square,
   output pfc_pkg::letter_type      res_a,
   output pfc_pkg::letter_type      res_b,
   output logic                     not_found
);
   import pfc_pkg::*;

   idx_type ra, ca, rb, cb;

   always_comb begin
      if (pos_a.row == pos_b.row) begin
         ra = pos_a.row;
         rb = pos_b.row;
         ca = wrap_step(pos_a.col, mode);
         cb = wrap_step(pos_b.col, mode);
      end else if (pos_a.col == pos_b.col) begin
         ra = wrap_step(pos_a.row, mode);
         rb = wrap_step(pos_b.row, mode);
         ca = pos_a.col;
         cb = pos_b.col;
      end else begin
         ra = pos_a.row;
         rb = pos_b.row;
         ca = pos_b.col;
         cb = pos_a.col;
      end
      not_found = !(pos_a.found && pos_b.found);
      if (not_found) begin
         res_a = '0;
         res_b = '0;
      end else begin
         res_a = square[ra][ca];
         res_b = square[rb][cb];
      end
   end

endmodule
`default_nettype wire
